@@ rtl/mbe_pkg.sv @@
// shared widths, codes, command and status types and saturating helpers
// for the escape-time block; no dependencies
package mbe_pkg;

   localparam int FRAC_BITS  = 36;
   localparam int COORD_BITS = 48;
   localparam int COUNT_BITS = 16;
   localparam int PIXEL_BITS = 12;
   localparam int LIMIT_BITS = 10;
   localparam int STEP_BITS  = COORD_BITS - 1;
   localparam int PROD_BITS  = 2 * COORD_BITS;
   localparam int DIST_BITS  = (2 * COORD_BITS + 1 > 2 * FRAC_BITS + LIMIT_BITS) ?
                               2 * COORD_BITS + 1 : 2 * FRAC_BITS + LIMIT_BITS;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   localparam logic signed [COORD_BITS-1:0] RST_MIN_REAL  = COORD_BITS'(-64'sd144310901146);
   localparam logic signed [COORD_BITS-1:0] RST_MAX_IMAG  = COORD_BITS'(64'sd57105884968);
   localparam logic [STEP_BITS-1:0]         RST_STEP_REAL = STEP_BITS'(64'd190352951);
   localparam logic [STEP_BITS-1:0]         RST_STEP_IMAG = STEP_BITS'(64'd190352951);
   localparam logic [COUNT_BITS-1:0]        RST_MAX_ITER  = COUNT_BITS'(512);
   localparam logic [LIMIT_BITS-1:0]        RST_ESC_LIMIT = LIMIT_BITS'(400);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MIN_REAL   = 3'd0,
      CSR_MAX_IMAG   = 3'd1,
      CSR_STEP_REAL  = 3'd2,
      CSR_STEP_IMAG  = 3'd3,
      CSR_MAX_ITER   = 3'd4,
      CSR_ESC_LIMIT  = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      MUL_MAP,
      MUL_ITER,
      MUL_SQ
   } mul_sel_type;

   typedef struct packed {
      mul_sel_type mul_sel;
      logic        load_pix;
      logic        init;
      logic        load_np;
      logic        load_z;
      logic        load_st;
   } cmd_type;

   typedef struct packed {
      logic more;
   } status_type;

   function automatic logic signed [COORD_BITS-1:0] sat_coord(
      input logic signed [PROD_BITS-1:0] x);
      logic all_ones;
      logic all_zeros;
      all_ones  = &x[PROD_BITS-1:COORD_BITS-1];
      all_zeros = ~|x[PROD_BITS-1:COORD_BITS-1];
      if (all_ones || all_zeros) begin
         return x[COORD_BITS-1:0];
      end else if (x[PROD_BITS-1]) begin
         return COORD_MIN;
      end else begin
         return COORD_MAX;
      end
   endfunction

   function automatic logic signed [COORD_BITS-1:0] shr_sat(
      input logic signed [PROD_BITS-1:0] x);
      logic signed [PROD_BITS-1:0] sh;
      sh = x >>> FRAC_BITS;
      return sat_coord(sh);
   endfunction

   function automatic logic signed [COORD_BITS-1:0] sat_add(
      input logic signed [COORD_BITS-1:0] a,
      input logic signed [COORD_BITS-1:0] b);
      logic signed [COORD_BITS:0] sum;
      sum = (COORD_BITS+1)'(a) + (COORD_BITS+1)'(b);
      if (sum[COORD_BITS] != sum[COORD_BITS-1]) begin
         return sum[COORD_BITS] ? COORD_MIN : COORD_MAX;
      end else begin
         return sum[COORD_BITS-1:0];
      end
   endfunction

   function automatic logic signed [COORD_BITS-1:0] sat_sub(
      input logic signed [COORD_BITS-1:0] a,
      input logic signed [COORD_BITS-1:0] b);
      logic signed [COORD_BITS:0] dif;
      dif = (COORD_BITS+1)'(a) - (COORD_BITS+1)'(b);
      if (dif[COORD_BITS] != dif[COORD_BITS-1]) begin
         return dif[COORD_BITS] ? COORD_MIN : COORD_MAX;
      end else begin
         return dif[COORD_BITS-1:0];
      end
   endfunction

endpackage

@@ rtl/mbe_mult.sv @@
// two-stage signed coordinate multiplier built from four half-width partial products
// depends on mbe_pkg for the coordinate and product widths
module mbe_mult (
   input  logic                                  clock,
   input  logic signed [mbe_pkg::COORD_BITS-1:0] a,
   input  logic signed [mbe_pkg::COORD_BITS-1:0] b,
   output logic signed [mbe_pkg::PROD_BITS-1:0]  prod
);

   localparam int LO_BITS = mbe_pkg::COORD_BITS / 2;
   localparam int HI_BITS = mbe_pkg::COORD_BITS - LO_BITS;

   logic signed [LO_BITS:0]   a_lo;
   logic signed [LO_BITS:0]   b_lo;
   logic signed [HI_BITS-1:0] a_hi;
   logic signed [HI_BITS-1:0] b_hi;

   logic signed [2*LO_BITS+1:0]     pp_ll_ff;
   logic signed [LO_BITS+HI_BITS:0] pp_lh_ff;
   logic signed [LO_BITS+HI_BITS:0] pp_hl_ff;
   logic signed [2*HI_BITS-1:0]     pp_hh_ff;

   logic signed [mbe_pkg::PROD_BITS-1:0] ext_ll;
   logic signed [mbe_pkg::PROD_BITS-1:0] ext_lh;
   logic signed [mbe_pkg::PROD_BITS-1:0] ext_hl;
   logic signed [mbe_pkg::PROD_BITS-1:0] ext_hh;
   logic signed [mbe_pkg::PROD_BITS-1:0] prod_ff;

   // low halves are unsigned, high halves carry the sign
   assign a_lo = {1'b0, a[LO_BITS-1:0]};
   assign b_lo = {1'b0, b[LO_BITS-1:0]};
   assign a_hi = a[mbe_pkg::COORD_BITS-1:LO_BITS];
   assign b_hi = b[mbe_pkg::COORD_BITS-1:LO_BITS];

   always_ff @(posedge clock) begin
      pp_ll_ff <= (2*LO_BITS+2)'(a_lo) * (2*LO_BITS+2)'(b_lo);
      pp_lh_ff <= (LO_BITS+HI_BITS+1)'(a_lo) * (LO_BITS+HI_BITS+1)'(b_hi);
      pp_hl_ff <= (LO_BITS+HI_BITS+1)'(a_hi) * (LO_BITS+HI_BITS+1)'(b_lo);
      pp_hh_ff <= (2*HI_BITS)'(a_hi) * (2*HI_BITS)'(b_hi);
   end

   always_comb begin
      ext_ll = mbe_pkg::PROD_BITS'(pp_ll_ff);
      ext_lh = mbe_pkg::PROD_BITS'(pp_lh_ff);
      ext_hl = mbe_pkg::PROD_BITS'(pp_hl_ff);
      ext_hh = mbe_pkg::PROD_BITS'(pp_hh_ff);
   end

   always_ff @(posedge clock) begin
      prod_ff <= ext_ll + ((ext_lh + ext_hl) <<< LO_BITS) + (ext_hh <<< (2 * LO_BITS));
   end

   assign prod = prod_ff;

endmodule

@@ rtl/mbe_datapath.sv @@
// escape-time datapath: configuration registers, point mapping, z update,
// magnitude test and iteration count; depends on mbe_pkg and mbe_mult
module mbe_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [mbe_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [mbe_pkg::COORD_BITS-1:0]        csr_wdata,
   input  logic [mbe_pkg::PIXEL_BITS-1:0]        req_column,
   input  logic [mbe_pkg::PIXEL_BITS-1:0]        req_row,
   input  mbe_pkg::cmd_type                      cmd,
   output mbe_pkg::status_type                   status,
   output logic [mbe_pkg::COUNT_BITS-1:0]        rsp_iterations,
   output logic                                  rsp_inside_res
);

   localparam int C = mbe_pkg::COORD_BITS;

   logic signed [C-1:0]                  min_real_ff;
   logic signed [C-1:0]                  max_imag_ff;
   logic [mbe_pkg::STEP_BITS-1:0]        step_real_ff;
   logic [mbe_pkg::STEP_BITS-1:0]        step_imag_ff;
   logic [mbe_pkg::COUNT_BITS-1:0]       max_iter_ff;
   logic [mbe_pkg::LIMIT_BITS-1:0]       esc_limit_ff;

   logic [mbe_pkg::PIXEL_BITS-1:0]       col_ff;
   logic [mbe_pkg::PIXEL_BITS-1:0]       row_ff;
   logic signed [C-1:0]                  cr_ff;
   logic signed [C-1:0]                  ci_ff;
   logic signed [C-1:0]                  zr_ff;
   logic signed [C-1:0]                  zi_ff;
   logic signed [C-1:0]                  s_ff;
   logic signed [C-1:0]                  t_ff;
   logic signed [C-1:0]                  nr_ff;
   logic signed [C-1:0]                  p_ff;
   logic [mbe_pkg::COUNT_BITS-1:0]       count_ff;

   logic signed [C-1:0]                  mul0_a;
   logic signed [C-1:0]                  mul0_b;
   logic signed [C-1:0]                  mul1_a;
   logic signed [C-1:0]                  mul1_b;
   logic signed [mbe_pkg::PROD_BITS-1:0] prod0;
   logic signed [mbe_pkg::PROD_BITS-1:0] prod1;
   logic signed [mbe_pkg::PROD_BITS-1:0] cr_sum;
   logic signed [mbe_pkg::PROD_BITS-1:0] ci_sum;
   logic [mbe_pkg::DIST_BITS-1:0]        dist_sq;
   logic [mbe_pkg::DIST_BITS-1:0]        lim;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_real_ff  <= mbe_pkg::RST_MIN_REAL;
         max_imag_ff  <= mbe_pkg::RST_MAX_IMAG;
         step_real_ff <= mbe_pkg::RST_STEP_REAL;
         step_imag_ff <= mbe_pkg::RST_STEP_IMAG;
         max_iter_ff  <= mbe_pkg::RST_MAX_ITER;
         esc_limit_ff <= mbe_pkg::RST_ESC_LIMIT;
      end else if (csr_we) begin
         unique case (mbe_pkg::csr_index_type'(csr_index))
            mbe_pkg::CSR_MIN_REAL:  min_real_ff  <= csr_wdata;
            mbe_pkg::CSR_MAX_IMAG:  max_imag_ff  <= csr_wdata;
            mbe_pkg::CSR_STEP_REAL: step_real_ff <= csr_wdata[mbe_pkg::STEP_BITS-1:0];
            mbe_pkg::CSR_STEP_IMAG: step_imag_ff <= csr_wdata[mbe_pkg::STEP_BITS-1:0];
            mbe_pkg::CSR_MAX_ITER:  max_iter_ff  <= csr_wdata[mbe_pkg::COUNT_BITS-1:0];
            mbe_pkg::CSR_ESC_LIMIT: esc_limit_ff <= csr_wdata[mbe_pkg::LIMIT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (cmd.mul_sel)
         mbe_pkg::MUL_MAP: begin
            mul0_a = {{(C-mbe_pkg::PIXEL_BITS){1'b0}}, col_ff};
            mul0_b = {1'b0, step_real_ff};
            mul1_a = {{(C-mbe_pkg::PIXEL_BITS){1'b0}}, row_ff};
            mul1_b = {1'b0, step_imag_ff};
         end
         mbe_pkg::MUL_ITER: begin
            mul0_a = s_ff;
            mul0_b = t_ff;
            mul1_a = zr_ff;
            mul1_b = zi_ff;
         end
         mbe_pkg::MUL_SQ: begin
            mul0_a = zr_ff;
            mul0_b = zr_ff;
            mul1_a = zi_ff;
            mul1_b = zi_ff;
         end
         default: begin
            mul0_a = s_ff;
            mul0_b = t_ff;
            mul1_a = zr_ff;
            mul1_b = zi_ff;
         end
      endcase
   end

   mbe_mult u_mult0 (
      .clock (clock),
      .a     (mul0_a),
      .b     (mul0_b),
      .prod  (prod0)
   );

   mbe_mult u_mult1 (
      .clock (clock),
      .a     (mul1_a),
      .b     (mul1_b),
      .prod  (prod1)
   );

   assign cr_sum = mbe_pkg::PROD_BITS'(min_real_ff) + prod0;
   assign ci_sum = mbe_pkg::PROD_BITS'(max_imag_ff) - prod1;

   always_ff @(posedge clock) begin
      if (cmd.load_pix) begin
         col_ff <= req_column;
         row_ff <= req_row;
      end
      if (cmd.init) begin
         cr_ff    <= mbe_pkg::sat_coord(cr_sum);
         ci_ff    <= mbe_pkg::sat_coord(ci_sum);
         zr_ff    <= '0;
         zi_ff    <= '0;
         s_ff     <= '0;
         t_ff     <= '0;
         count_ff <= '0;
      end
      if (cmd.load_np) begin
         nr_ff <= mbe_pkg::shr_sat(prod0);
         p_ff  <= mbe_pkg::shr_sat(prod1);
      end
      if (cmd.load_z) begin
         zr_ff    <= mbe_pkg::sat_add(nr_ff, cr_ff);
         zi_ff    <= mbe_pkg::sat_add(mbe_pkg::sat_add(p_ff, p_ff), ci_ff);
         count_ff <= count_ff + mbe_pkg::COUNT_BITS'(1);
      end
      if (cmd.load_st) begin
         s_ff <= mbe_pkg::sat_sub(zr_ff, zi_ff);
         t_ff <= mbe_pkg::sat_add(zr_ff, zi_ff);
      end
   end

   // squares are never negative, so zero extension is exact
   assign dist_sq = mbe_pkg::DIST_BITS'($unsigned(prod0))
                    + mbe_pkg::DIST_BITS'($unsigned(prod1));
   assign lim     = mbe_pkg::DIST_BITS'(esc_limit_ff) << (2 * mbe_pkg::FRAC_BITS);

   assign status.more    = (dist_sq < lim) && (count_ff < max_iter_ff);
   assign rsp_iterations = count_ff;
   assign rsp_inside_res = (count_ff == max_iter_ff);

endmodule

@@ rtl/mbe_ctrl.sv @@
// escape-time sequencer: steps the datapath through mapping and iterations
// and strobes the result; depends on mbe_pkg
module mbe_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  mbe_pkg::status_type status,
   output logic                busy,
   output logic                rsp_valid,
   output mbe_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAP_ISSUE,
      ST_MAP_WAIT,
      ST_MAP_LOAD,
      ST_IT_MUL,
      ST_IT_WAIT1,
      ST_IT_SHIFT,
      ST_IT_UPD,
      ST_IT_SQ,
      ST_IT_WAIT2,
      ST_IT_CMP
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE:      if (start) state_in = ST_MAP_ISSUE;
         ST_MAP_ISSUE: state_in = ST_MAP_WAIT;
         ST_MAP_WAIT:  state_in = ST_MAP_LOAD;
         ST_MAP_LOAD:  state_in = ST_IT_MUL;
         ST_IT_MUL:    state_in = ST_IT_WAIT1;
         ST_IT_WAIT1:  state_in = ST_IT_SHIFT;
         ST_IT_SHIFT:  state_in = ST_IT_UPD;
         ST_IT_UPD:    state_in = ST_IT_SQ;
         ST_IT_SQ:     state_in = ST_IT_WAIT2;
         ST_IT_WAIT2:  state_in = ST_IT_CMP;
         ST_IT_CMP: begin
            if (status.more) begin
               state_in = ST_IT_MUL;
            end else begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      cmd          = '0;
      cmd.mul_sel  = mbe_pkg::MUL_ITER;
      unique case (state_ff)
         ST_IDLE:      cmd.load_pix = 1'b1;
         ST_MAP_ISSUE: cmd.mul_sel  = mbe_pkg::MUL_MAP;
         ST_MAP_WAIT:  cmd.mul_sel  = mbe_pkg::MUL_MAP;
         ST_MAP_LOAD:  cmd.init     = 1'b1;
         ST_IT_MUL:    cmd.mul_sel  = mbe_pkg::MUL_ITER;
         ST_IT_WAIT1:  cmd.mul_sel  = mbe_pkg::MUL_ITER;
         ST_IT_SHIFT:  cmd.load_np  = 1'b1;
         ST_IT_UPD:    cmd.load_z   = 1'b1;
         ST_IT_SQ:     cmd.mul_sel  = mbe_pkg::MUL_SQ;
         ST_IT_WAIT2:  cmd.mul_sel  = mbe_pkg::MUL_SQ;
         ST_IT_CMP: begin
            cmd.mul_sel = mbe_pkg::MUL_SQ;
            cmd.load_st = 1'b1;
         end
         default: ;
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transfer did not start work");

   a_rsp_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_rsp_after_test: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_IT_CMP))
      else $error("result strobe without a final magnitude test");

endmodule

@@ rtl/mandelbrot_escape_time.sv @@
// Escape-time iteration for one pixel. A pixel transfer is accepted at a rising
// edge with start high and busy low; req_column and req_row are taken then.
// Configuration: csr_we writes csr_wdata to register csr_index at any edge
// (0 min_real, 1 max_imag, 2 step_real, 3 step_imag, 4 max_iterations,
// 5 escape_limit); other indexes are ignored. Write only while idle.
// Result: rsp_iterations and rsp_inside_res are valid for exactly one cycle
// with rsp_valid; the receiver cannot stall and must take it then.
// After the accepting edge the block runs the mapping states (issue, wait,
// load) and then the iterations; busy falls in the strobe cycle, so a new
// pixel can be accepted at its end.
// Each iteration goes through the pair of two-stage multipliers:
// one pass for (zr-zi)*(zr+zi) and zr*zi, one pass for the squared magnitude.
// Reset (synchronous) returns the configuration registers to their defaults
// and the block to idle with no result pending.
// depends on mbe_pkg, mbe_ctrl, mbe_datapath
module mandelbrot_escape_time (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [mbe_pkg::PIXEL_BITS-1:0]     req_column,
   input  logic [mbe_pkg::PIXEL_BITS-1:0]     req_row,
   output logic                               rsp_valid,
   output logic [mbe_pkg::COUNT_BITS-1:0]     rsp_iterations,
   output logic                               rsp_inside_res,
   input  logic                               csr_we,
   input  logic [mbe_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mbe_pkg::COORD_BITS-1:0]     csr_wdata
);

   mbe_pkg::cmd_type    cmd;
   mbe_pkg::status_type status;

   mbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   mbe_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_column     (req_column),
      .req_row        (req_row),
      .cmd            (cmd),
      .status         (status),
      .rsp_iterations (rsp_iterations),
      .rsp_inside_res (rsp_inside_res)
   );

   a_rsp_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_iterations != '0)
      else $error("result transfer with zero iterations");

endmodule
